>>> rtl/kdl_pkg.sv
// package for the keypad door lock controller: phases, codes, shared types
package kdl_pkg;

	// code length and digit index width
	localparam int CODE_LEN = 5;
	localparam int IDX_W = (CODE_LEN > 1) ? $clog2(CODE_LEN) : 1;

	// reply bytes and key codes
	localparam logic [7:0] REPLY_MATCH   = 8'h11;
	localparam logic [7:0] REPLY_DIFFER  = 8'hFF;
	localparam logic [7:0] KEY_ENTER     = 8'h0D;
	localparam logic [7:0] CHOICE_OPEN   = 8'd11;
	localparam logic [7:0] CHOICE_CHANGE = 8'd13;

	// item kinds on the input tuser bit
	localparam logic FUNC_BYTE = 1'b0;
	localparam logic FUNC_TICK = 1'b1;

	// motor drive codes
	localparam logic [1:0] MOTOR_STOP    = 2'd0;
	localparam logic [1:0] MOTOR_FORWARD = 2'd1;
	localparam logic [1:0] MOTOR_REVERSE = 2'd2;

	// configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 8;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_TRIES      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LOCKOUT_TICKS  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_OPEN_END_TICK  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_HOLD_END_TICK  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CLOSE_END_TICK = 3'd4;

	// configuration reset values
	localparam logic [3:0] MAX_TRIES_RST      = 4'd3;
	localparam logic [7:0] LOCKOUT_TICKS_RST  = 8'd20;
	localparam logic [7:0] OPEN_END_TICK_RST  = 8'd5;
	localparam logic [7:0] HOLD_END_TICK_RST  = 8'd6;
	localparam logic [7:0] CLOSE_END_TICK_RST = 8'd11;

	// controller phases
	typedef enum logic [3:0] {
		PH_NEW_FIRST  = 4'd0,
		PH_NEW_SECOND = 4'd1,
		PH_NEW_WAIT   = 4'd2,
		PH_IDLE       = 4'd3,
		PH_CHECK      = 4'd4,
		PH_CHECK_WAIT = 4'd5,
		PH_LOCKOUT    = 4'd6,
		PH_FORWARD    = 4'd7,
		PH_HOLD       = 4'd8,
		PH_REVERSE    = 4'd9
	} phase_t;

	// configuration register set
	typedef struct packed {
		logic [3:0] max_tries;
		logic [7:0] lockout_ticks;
		logic [7:0] open_end_tick;
		logic [7:0] hold_end_tick;
		logic [7:0] close_end_tick;
	} cfg_t;

	// one result item
	typedef struct packed {
		logic       reply_valid;
		logic [7:0] reply_byte;
		logic [1:0] motor_dir;
		logic       alarm_on;
		logic       busy_res;
	} result_t;

endpackage

>>> rtl/kdl_core.sv
// lock state machine: code entry, code check, lockout and motor sequence
module kdl_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  logic             func,
	input  logic [7:0]       rx_byte,
	input  kdl_pkg::cfg_t    cfg,
	output kdl_pkg::result_t res
);

	kdl_pkg::phase_t              phase_q, phase_nxt;
	logic [kdl_pkg::IDX_W-1:0]    digit_q, digit_nxt;
	logic                         mismatch_q, mismatch_nxt;
	logic                         matched_q, matched_nxt;
	logic [3:0]                   tries_q, tries_nxt;
	logic [7:0]                   tick_q, tick_nxt;
	logic                         change_q, change_nxt;
	logic [7:0]                   first_entry_q [kdl_pkg::CODE_LEN];
	logic [7:0]                   stored_code_q [kdl_pkg::CODE_LEN];
	logic                         first_we;
	logic                         copy_en;
	logic                         last_digit;
	logic                         busy_phase;
	logic                         reply_valid_c;
	logic [7:0]                   reply_byte_c;

	// tick marks, checked in order so equal marks pass several steps
	function automatic kdl_pkg::phase_t settle(kdl_pkg::phase_t ph, logic [7:0] cnt,
			kdl_pkg::cfg_t c);
		kdl_pkg::phase_t p;
		p = ph;
		if (p == kdl_pkg::PH_LOCKOUT && cnt == c.lockout_ticks) p = kdl_pkg::PH_IDLE;
		if (p == kdl_pkg::PH_FORWARD && cnt == c.open_end_tick) p = kdl_pkg::PH_HOLD;
		if (p == kdl_pkg::PH_HOLD && cnt == c.hold_end_tick) p = kdl_pkg::PH_REVERSE;
		if (p == kdl_pkg::PH_REVERSE && cnt == c.close_end_tick) p = kdl_pkg::PH_IDLE;
		return p;
	endfunction

	assign last_digit = (digit_q == kdl_pkg::IDX_W'(kdl_pkg::CODE_LEN - 1));
	assign busy_phase = (phase_q == kdl_pkg::PH_LOCKOUT) || (phase_q == kdl_pkg::PH_FORWARD)
		|| (phase_q == kdl_pkg::PH_HOLD) || (phase_q == kdl_pkg::PH_REVERSE);

	// next state and reply for one item
	always_comb begin
		phase_nxt     = phase_q;
		digit_nxt     = digit_q;
		mismatch_nxt  = mismatch_q;
		matched_nxt   = matched_q;
		tries_nxt     = tries_q;
		tick_nxt      = tick_q;
		change_nxt    = change_q;
		first_we      = 1'b0;
		copy_en       = 1'b0;
		reply_valid_c = 1'b0;
		reply_byte_c  = 8'd0;
		if (func == kdl_pkg::FUNC_TICK) begin
			if (busy_phase) begin
				tick_nxt  = tick_q + 8'd1;
				phase_nxt = settle(phase_q, tick_nxt, cfg);
			end
		end else begin
			case (phase_q)
				kdl_pkg::PH_NEW_FIRST: begin
					first_we = 1'b1;
					if (last_digit) begin
						digit_nxt    = '0;
						mismatch_nxt = 1'b0;
						phase_nxt    = kdl_pkg::PH_NEW_SECOND;
					end else begin
						digit_nxt = digit_q + 1'b1;
					end
				end
				kdl_pkg::PH_NEW_SECOND: begin
					if (first_entry_q[digit_q] != rx_byte) mismatch_nxt = 1'b1;
					if (last_digit) begin
						digit_nxt     = '0;
						matched_nxt   = !mismatch_nxt;
						reply_valid_c = 1'b1;
						reply_byte_c  = matched_nxt ? kdl_pkg::REPLY_MATCH
							: kdl_pkg::REPLY_DIFFER;
						copy_en       = matched_nxt;
						phase_nxt     = kdl_pkg::PH_NEW_WAIT;
					end else begin
						digit_nxt = digit_q + 1'b1;
					end
				end
				kdl_pkg::PH_NEW_WAIT: begin
					if (rx_byte == kdl_pkg::KEY_ENTER) begin
						digit_nxt = '0;
						phase_nxt = matched_q ? kdl_pkg::PH_IDLE : kdl_pkg::PH_NEW_FIRST;
					end
				end
				kdl_pkg::PH_IDLE: begin
					if (rx_byte == kdl_pkg::CHOICE_OPEN || rx_byte == kdl_pkg::CHOICE_CHANGE)
					begin
						change_nxt   = (rx_byte == kdl_pkg::CHOICE_CHANGE);
						tries_nxt    = 4'd0;
						digit_nxt    = '0;
						mismatch_nxt = 1'b0;
						phase_nxt    = kdl_pkg::PH_CHECK;
					end
				end
				kdl_pkg::PH_CHECK: begin
					if (stored_code_q[digit_q] != rx_byte) mismatch_nxt = 1'b1;
					if (last_digit) begin
						digit_nxt     = '0;
						matched_nxt   = !mismatch_nxt;
						reply_valid_c = 1'b1;
						reply_byte_c  = matched_nxt ? kdl_pkg::REPLY_MATCH
							: kdl_pkg::REPLY_DIFFER;
						tries_nxt     = tries_q + 4'd1;
						phase_nxt     = kdl_pkg::PH_CHECK_WAIT;
					end else begin
						digit_nxt = digit_q + 1'b1;
					end
				end
				kdl_pkg::PH_CHECK_WAIT: begin
					if (rx_byte == kdl_pkg::KEY_ENTER) begin
						digit_nxt    = '0;
						mismatch_nxt = 1'b0;
						if (matched_q) begin
							tries_nxt = 4'd0;
							if (change_q) begin
								phase_nxt = kdl_pkg::PH_NEW_FIRST;
							end else begin
								tick_nxt  = 8'd0;
								phase_nxt = settle(kdl_pkg::PH_FORWARD, 8'd0, cfg);
							end
						end else if (tries_q >= cfg.max_tries) begin
							tries_nxt = 4'd0;
							tick_nxt  = 8'd0;
							phase_nxt = settle(kdl_pkg::PH_LOCKOUT, 8'd0, cfg);
						end else begin
							phase_nxt = kdl_pkg::PH_CHECK;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	// reply and actuator outputs after the item
	always_comb begin
		res.reply_valid = reply_valid_c;
		res.reply_byte  = reply_byte_c;
		case (phase_nxt)
			kdl_pkg::PH_FORWARD: res.motor_dir = kdl_pkg::MOTOR_FORWARD;
			kdl_pkg::PH_REVERSE: res.motor_dir = kdl_pkg::MOTOR_REVERSE;
			default:             res.motor_dir = kdl_pkg::MOTOR_STOP;
		endcase
		res.alarm_on = (phase_nxt == kdl_pkg::PH_LOCKOUT);
		res.busy_res = (phase_nxt == kdl_pkg::PH_LOCKOUT) || (phase_nxt == kdl_pkg::PH_FORWARD)
			|| (phase_nxt == kdl_pkg::PH_HOLD) || (phase_nxt == kdl_pkg::PH_REVERSE);
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= kdl_pkg::PH_NEW_FIRST;
			digit_q    <= '0;
			mismatch_q <= 1'b0;
			matched_q  <= 1'b0;
			tries_q    <= 4'd0;
			tick_q     <= 8'd0;
			change_q   <= 1'b0;
		end else if (step) begin
			phase_q    <= phase_nxt;
			digit_q    <= digit_nxt;
			mismatch_q <= mismatch_nxt;
			matched_q  <= matched_nxt;
			tries_q    <= tries_nxt;
			tick_q     <= tick_nxt;
			change_q   <= change_nxt;
		end
	end

	// code stores, undefined until written
	always_ff @(posedge clk) begin
		if (step && first_we) first_entry_q[digit_q] <= rx_byte;
		if (step && copy_en) begin
			for (int i = 0; i < kdl_pkg::CODE_LEN; i++) stored_code_q[i] <= first_entry_q[i];
		end
	end

endmodule

>>> rtl/keypad_door_lock_controller.sv
// top level of the keypad door lock controller: stream ports, config registers, pipeline
// Each request on the slave side is a received byte (s_tuser low) or a timer tick
// (s_tuser high) and yields exactly one result on the master side. An item sits in an
// input register, where the lock state machine updates its state and forms the result,
// then lands in a result register; one item is taken every cycle unless the result
// side stalls. The block keeps accepting while a result waits, as long as the
// result register frees up in the same cycle. After reset the user enters a new code twice
// and confirms with Enter; afterwards the open choice byte starts a code check that runs
// the door motor and the change choice byte starts one that leads to new code entry.
// Configuration writes belong to idle periods only.
module keypad_door_lock_controller (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [7:0]                      s_tdata,   // rx_byte[7:0]
	input  logic                            s_tuser,   // func[0]
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [15:0]                     m_tdata,   // reply_byte[7:0], motor_dir[9:8],
	                                                   // alarm_on[10], busy_res[11], zero
	output logic                            m_tuser,   // reply_valid[0]
	input  logic                            cfg_we,
	input  logic [kdl_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [kdl_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

	kdl_pkg::cfg_t    cfg_q;
	logic             in_valid_s1;
	logic             func_s1;
	logic [7:0]       byte_s1;
	logic             out_valid_s2;
	kdl_pkg::result_t res_s2;
	kdl_pkg::result_t res_comb;
	logic             advance;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_tries      <= kdl_pkg::MAX_TRIES_RST;
			cfg_q.lockout_ticks  <= kdl_pkg::LOCKOUT_TICKS_RST;
			cfg_q.open_end_tick  <= kdl_pkg::OPEN_END_TICK_RST;
			cfg_q.hold_end_tick  <= kdl_pkg::HOLD_END_TICK_RST;
			cfg_q.close_end_tick <= kdl_pkg::CLOSE_END_TICK_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				kdl_pkg::REG_MAX_TRIES:      cfg_q.max_tries      <= cfg_wdata[3:0];
				kdl_pkg::REG_LOCKOUT_TICKS:  cfg_q.lockout_ticks  <= cfg_wdata;
				kdl_pkg::REG_OPEN_END_TICK:  cfg_q.open_end_tick  <= cfg_wdata;
				kdl_pkg::REG_HOLD_END_TICK:  cfg_q.hold_end_tick  <= cfg_wdata;
				kdl_pkg::REG_CLOSE_END_TICK: cfg_q.close_end_tick <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	// handshake: stage 1 moves on when the result register is free or drains
	assign advance  = in_valid_s1 && (!out_valid_s2 || m_tready);
	assign s_tready = !in_valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (s_tready) begin
			in_valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			func_s1 <= s_tuser;
			byte_s1 <= s_tdata;
		end
	end

	// lock state machine
	kdl_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (advance),
		.func    (func_s1),
		.rx_byte (byte_s1),
		.cfg     (cfg_q),
		.res     (res_comb)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (advance) begin
			out_valid_s2 <= 1'b1;
		end else if (m_tready) begin
			out_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) res_s2 <= res_comb;
	end

	// result packing
	assign m_tvalid = out_valid_s2;
	assign m_tuser  = res_s2.reply_valid;
	assign m_tdata  = {4'd0, res_s2.busy_res, res_s2.alarm_on, res_s2.motor_dir,
		res_s2.reply_byte};

endmodule

>>> tb/keypad_door_lock_controller_tb.sv
`timescale 1ns / 1ps
// testbench for the keypad door lock controller: scripted and random requests against a predictor
module keypad_door_lock_controller_tb;
	import kdl_pkg::*;

	localparam int LIMIT         = 400000;
	localparam int RANDOM_TARGET = 1400;
	localparam int N_SETTINGS    = 6;
	localparam int SETTLE        = 8;
	localparam int MAX_PRINTS    = 50;
	localparam int N_SCRIPT      = 26;

	// one row of the scripted opening: request, and a typed result where it is obvious
	typedef struct packed {
		logic       func;
		logic [7:0] data;
		logic       typed;
		result_t    want;
	} script_row_t;

	localparam logic    TYPED     = 1'b1;
	localparam logic    PREDICTED = 1'b0;
	localparam result_t QUIET     = '0;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [7:0]            s_tdata   = 8'h00;
	logic                  s_tuser   = FUNC_BYTE;
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic [15:0]           m_tdata;
	logic                  m_tuser;
	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = REG_MAX_TRIES;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;

	keypad_door_lock_controller i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	// predicted lock state and register copy
	cfg_t        lock_cfg;
	phase_t      lk_phase;
	int unsigned lk_digit;
	logic [7:0]  lk_first [CODE_LEN];
	logic [7:0]  lk_code [CODE_LEN];
	logic        lk_mismatch;
	logic        lk_matched;
	logic        lk_change;
	logic [3:0]  lk_tries;
	logic [7:0]  lk_ticks;

	// results still owed by the block, oldest first
	result_t pending_results [$];

	int unsigned n_cycles = 0;
	int unsigned n_errors = 0;
	int unsigned n_requests = 0;
	int unsigned n_acted = 0;
	int unsigned n_match = 0;
	int unsigned n_differ = 0;
	int unsigned n_door_runs = 0;
	int unsigned n_lockouts = 0;
	int unsigned tx_idle_pct = 28;
	int unsigned rx_idle_pct = 67;

	// plan for the code entry under way: right or wrong, and where it goes wrong
	bit          plan_good;
	int unsigned plan_slot;

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// run limit
	always @(posedge clk) begin
		n_cycles++;
		if (n_cycles > LIMIT) begin
			$display("keypad_door_lock_controller: mismatch");
			$finish;
		end
	end

	task automatic report(input string what, input int unsigned want, input int unsigned got);
		n_errors++;
		if (n_errors <= MAX_PRINTS)
			$display("%0t: %s expected 0x%0h got 0x%0h", $time, what, want, got);
	endtask

	function automatic bit lock_busy();
		return lk_phase >= PH_LOCKOUT && lk_phase <= PH_REVERSE;
	endfunction

	task automatic lock_reset();
		lock_cfg = {MAX_TRIES_RST, LOCKOUT_TICKS_RST, OPEN_END_TICK_RST, HOLD_END_TICK_RST,
			CLOSE_END_TICK_RST};
		lk_phase = PH_NEW_FIRST;
		lk_digit = 0;
		for (int i = 0; i < CODE_LEN; i++) begin
			lk_first[i] = 8'h00;
			lk_code[i] = 8'h00;
		end
		lk_mismatch = 1'b0;
		lk_matched = 1'b0;
		lk_change = 1'b0;
		lk_tries = '0;
		lk_ticks = '0;
	endtask

	// marks are taken in order, so equal marks fall through several steps at once
	task automatic pass_tick_marks();
		if (lk_phase == PH_LOCKOUT && lk_ticks == lock_cfg.lockout_ticks)
			lk_phase = PH_IDLE;
		if (lk_phase == PH_FORWARD && lk_ticks == lock_cfg.open_end_tick)
			lk_phase = PH_HOLD;
		if (lk_phase == PH_HOLD && lk_ticks == lock_cfg.hold_end_tick)
			lk_phase = PH_REVERSE;
		if (lk_phase == PH_REVERSE && lk_ticks == lock_cfg.close_end_tick)
			lk_phase = PH_IDLE;
	endtask

	// lock predictor: advance the state by one request and form its result
	task automatic predict_lock(input logic func, input logic [7:0] b, output result_t res,
			output bit acted);
		logic last_digit;
		res = '0;
		acted = 1'b0;
		last_digit = (lk_digit + 1 >= CODE_LEN);
		if (func == FUNC_TICK) begin
			if (lock_busy()) begin
				acted = 1'b1;
				lk_ticks = lk_ticks + 8'd1;
				pass_tick_marks();
			end
		end else begin
			case (lk_phase)
				PH_NEW_FIRST: begin
					acted = 1'b1;
					lk_first[lk_digit] = b;
					if (last_digit) begin
						lk_digit = 0;
						lk_mismatch = 1'b0;
						lk_phase = PH_NEW_SECOND;
					end else begin
						lk_digit++;
					end
				end
				PH_NEW_SECOND: begin
					acted = 1'b1;
					if (lk_first[lk_digit] != b)
						lk_mismatch = 1'b1;
					if (last_digit) begin
						lk_digit = 0;
						lk_matched = !lk_mismatch;
						res.reply_valid = 1'b1;
						res.reply_byte = lk_matched ? REPLY_MATCH : REPLY_DIFFER;
						if (lk_matched)
							lk_code = lk_first;
						lk_phase = PH_NEW_WAIT;
					end else begin
						lk_digit++;
					end
				end
				PH_NEW_WAIT: if (b == KEY_ENTER) begin
					acted = 1'b1;
					lk_digit = 0;
					lk_phase = lk_matched ? PH_IDLE : PH_NEW_FIRST;
				end
				PH_IDLE: if (b == CHOICE_OPEN || b == CHOICE_CHANGE) begin
					acted = 1'b1;
					lk_change = (b == CHOICE_CHANGE);
					lk_tries = '0;
					lk_digit = 0;
					lk_mismatch = 1'b0;
					lk_phase = PH_CHECK;
				end
				PH_CHECK: begin
					acted = 1'b1;
					if (lk_code[lk_digit] != b)
						lk_mismatch = 1'b1;
					if (last_digit) begin
						lk_digit = 0;
						lk_matched = !lk_mismatch;
						res.reply_valid = 1'b1;
						res.reply_byte = lk_matched ? REPLY_MATCH : REPLY_DIFFER;
						lk_tries = lk_tries + 4'd1;
						lk_phase = PH_CHECK_WAIT;
					end else begin
						lk_digit++;
					end
				end
				PH_CHECK_WAIT: if (b == KEY_ENTER) begin
					acted = 1'b1;
					lk_digit = 0;
					lk_mismatch = 1'b0;
					if (lk_matched) begin
						lk_tries = '0;
						if (lk_change) begin
							lk_phase = PH_NEW_FIRST;
						end else begin
							lk_ticks = '0;
							lk_phase = PH_FORWARD;
							n_door_runs++;
							pass_tick_marks();
						end
					end else if (lk_tries >= lock_cfg.max_tries) begin
						lk_tries = '0;
						lk_ticks = '0;
						lk_phase = PH_LOCKOUT;
						n_lockouts++;
						pass_tick_marks();
					end else begin
						lk_phase = PH_CHECK;
					end
				end
				default: ;
			endcase
		end
		if (res.reply_valid) begin
			if (res.reply_byte == REPLY_MATCH)
				n_match++;
			else
				n_differ++;
		end
		res.motor_dir = (lk_phase == PH_FORWARD) ? MOTOR_FORWARD :
			(lk_phase == PH_REVERSE) ? MOTOR_REVERSE : MOTOR_STOP;
		res.alarm_on = (lk_phase == PH_LOCKOUT);
		res.busy_res = lock_busy();
	endtask

	// opening script: both code entries, a failed and a good check, then the door run
	function automatic script_row_t script_at(int n);
		script_row_t row;
		row = {FUNC_BYTE, 8'h00, PREDICTED, QUIET};
		case (n)
			0:  row = {FUNC_TICK, 8'h00, TYPED, QUIET};
			1:  row = {FUNC_BYTE, 8'h00, PREDICTED, QUIET};
			2:  row = {FUNC_BYTE, 8'hFF, PREDICTED, QUIET};
			3:  row = {FUNC_BYTE, KEY_ENTER, PREDICTED, QUIET};
			4:  row = {FUNC_BYTE, CHOICE_OPEN, PREDICTED, QUIET};
			5:  row = {FUNC_BYTE, CHOICE_CHANGE, PREDICTED, QUIET};
			6:  row = {FUNC_BYTE, 8'h00, PREDICTED, QUIET};
			7:  row = {FUNC_BYTE, 8'hFF, PREDICTED, QUIET};
			8:  row = {FUNC_BYTE, KEY_ENTER, PREDICTED, QUIET};
			9:  row = {FUNC_BYTE, CHOICE_OPEN, PREDICTED, QUIET};
			10: row = {FUNC_BYTE, CHOICE_CHANGE, TYPED, 1'b1, REPLY_MATCH, MOTOR_STOP, 1'b0, 1'b0};
			11: row = {FUNC_BYTE, KEY_ENTER, PREDICTED, QUIET};
			12: row = {FUNC_TICK, 8'hA5, PREDICTED, QUIET};
			13: row = {FUNC_BYTE, CHOICE_OPEN, PREDICTED, QUIET};
			14: row = {FUNC_BYTE, 8'h01, PREDICTED, QUIET};
			15: row = {FUNC_BYTE, 8'h02, PREDICTED, QUIET};
			16: row = {FUNC_BYTE, 8'h04, PREDICTED, QUIET};
			17: row = {FUNC_BYTE, 8'h08, PREDICTED, QUIET};
			18: row = {FUNC_BYTE, 8'h10, TYPED, 1'b1, REPLY_DIFFER, MOTOR_STOP, 1'b0, 1'b0};
			19: row = {FUNC_BYTE, KEY_ENTER, PREDICTED, QUIET};
			20: row = {FUNC_BYTE, 8'h00, PREDICTED, QUIET};
			21: row = {FUNC_BYTE, 8'hFF, PREDICTED, QUIET};
			22: row = {FUNC_BYTE, KEY_ENTER, PREDICTED, QUIET};
			23: row = {FUNC_BYTE, CHOICE_OPEN, PREDICTED, QUIET};
			24: row = {FUNC_BYTE, CHOICE_CHANGE, TYPED, 1'b1, REPLY_MATCH, MOTOR_STOP, 1'b0, 1'b0};
			25: row = {FUNC_BYTE, KEY_ENTER, TYPED, 1'b0, 8'h00, MOTOR_FORWARD, 1'b0, 1'b1};
			default: ;
		endcase
		return row;
	endfunction

	// register settings per run segment: reset values, top, bottom, zero marks, wrapped marks, random values
	function automatic cfg_t settings_for(int s);
		cfg_t c;
		c = {MAX_TRIES_RST, LOCKOUT_TICKS_RST, OPEN_END_TICK_RST, HOLD_END_TICK_RST,
			CLOSE_END_TICK_RST};
		case (s)
			1: c = {4'd15, 8'd255, 8'd255, 8'd255, 8'd255};
			2: c = {4'd1, 8'd1, 8'd1, 8'd1, 8'd1};
			3: c = '0;
			4: c = {4'($urandom_range(1, 15)), 8'd40, 8'd200, 8'd10, 8'd5};
			5: c = {4'($urandom_range(1, 15)), 8'($urandom_range(1, 255)),
				8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)),
				8'($urandom_range(1, 255))};
			default: ;
		endcase
		return c;
	endfunction

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(posedge clk);
	endtask

	task automatic write_settings(input cfg_t c);
		write_reg(REG_MAX_TRIES, {4'd0, c.max_tries});
		write_reg(REG_LOCKOUT_TICKS, c.lockout_ticks);
		write_reg(REG_OPEN_END_TICK, c.open_end_tick);
		write_reg(REG_HOLD_END_TICK, c.hold_end_tick);
		write_reg(REG_CLOSE_END_TICK, c.close_end_tick);
		cfg_we <= 1'b0;
		lock_cfg = c;
	endtask

	// hold off requests until every owed result is back and the pipeline is empty
	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// pick the next request from the predicted phase: mostly well-formed, some noise
	task automatic choose_request(output logic f, output logic [7:0] b);
		logic [7:0] right;
		f = FUNC_BYTE;
		b = 8'($urandom_range(255));
		if ($urandom_range(99) < 8) begin
			f = 1'($urandom_range(1));
			return;
		end
		if (lk_digit == 0) begin
			plan_good = ($urandom_range(99) < 60);
			plan_slot = $urandom_range(CODE_LEN - 1);
		end
		case (lk_phase)
			PH_NEW_FIRST: begin
				case ($urandom_range(9))
					0: b = KEY_ENTER;
					1: b = CHOICE_OPEN;
					2: b = CHOICE_CHANGE;
					default: ;
				endcase
			end
			PH_NEW_SECOND, PH_CHECK: begin
				right = (lk_phase == PH_CHECK) ? lk_code[lk_digit] : lk_first[lk_digit];
				if (!plan_good && lk_digit == plan_slot)
					b = right ^ 8'($urandom_range(1, 255));
				else
					b = right;
			end
			PH_NEW_WAIT, PH_CHECK_WAIT: begin
				if ($urandom_range(99) < 85)
					b = KEY_ENTER;
			end
			PH_IDLE: begin
				case ($urandom_range(9))
					0, 1, 2, 3, 4, 5: b = CHOICE_OPEN;
					6, 7: b = CHOICE_CHANGE;
					default: ;
				endcase
			end
			default: begin
				if ($urandom_range(99) < 88)
					f = FUNC_TICK;
			end
		endcase
	endtask

	// send one request, log its expected result, and maybe idle afterwards
	task automatic send_request(input logic func, input logic [7:0] b, input logic typed,
			input result_t want);
		result_t guess;
		bit      acted;
		s_tvalid <= 1'b1;
		s_tuser <= func;
		s_tdata <= b;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		predict_lock(func, b, guess, acted);
		pending_results.push_back(typed ? want : guess);
		n_requests++;
		if (acted)
			n_acted++;
		if ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	// result side: compare each accepted result with the oldest expectation
	always @(posedge clk) begin : result_side
		result_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (pending_results.size() == 0) begin
					report("result with none owed, data", 0, m_tdata);
				end else begin
					want = pending_results.pop_front();
					if (m_tuser !== want.reply_valid)
						report("reply_valid", want.reply_valid, m_tuser);
					if (m_tdata[7:0] !== want.reply_byte)
						report("reply_byte", want.reply_byte, m_tdata[7:0]);
					if (m_tdata[9:8] !== want.motor_dir)
						report("motor_dir", want.motor_dir, m_tdata[9:8]);
					if (m_tdata[10] !== want.alarm_on)
						report("alarm_on", want.alarm_on, m_tdata[10]);
					if (m_tdata[11] !== want.busy_res)
						report("busy_res", want.busy_res, m_tdata[11]);
				end
			end
			m_tready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	// main sequence: reset, script, then random segments under each register setting
	initial begin : stimulus
		script_row_t row;
		logic        f;
		logic [7:0]  b;
		int unsigned goal;
		lock_reset();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int n = 0; n < N_SCRIPT; n++) begin
			row = script_at(n);
			send_request(row.func, row.data, row.typed, row.want);
		end
		for (int s = 0; s < N_SETTINGS; s++) begin
			if (s != 0) begin
				drain();
				write_settings(settings_for(s));
			end
			if (s == 2) begin
				tx_idle_pct = 67;
				rx_idle_pct = 28;
			end else if (s == 4) begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end
			goal = n_requests + RANDOM_TARGET / N_SETTINGS;
			while (n_requests < goal) begin
				choose_request(f, b);
				send_request(f, b, PREDICTED, QUIET);
			end
		end
		drain();
		$display("run covered %0d requests (%0d taking effect) under %0d register settings",
			n_requests, n_acted, N_SETTINGS);
		$display("code replies: %0d matched, %0d differed; %0d door runs, %0d lockouts",
			n_match, n_differ, n_door_runs, n_lockouts);
		if (n_errors == 0) begin
			$display("keypad_door_lock_controller: match");
		end else begin
			$display("keypad_door_lock_controller: mismatch");
		end
		$finish;
	end

endmodule
